// ===== hdl/sha1bc_pkg.sv =====
// Shared types and sizes for the SHA-1 block compression core.
package sha1bc_pkg;

  // One 32-bit word of the chaining value, schedule or working state.
  typedef logic [31:0] word_t;

  // The five working variables A to E.
  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
  } vars_t;

  // Operation codes of an input word.
  localparam logic OpLoad    = 1'b0;
  localparam logic OpMessage = 1'b1;

  // Sizes of the algorithm.
  localparam int unsigned NumChain  = 5;
  localparam int unsigned NumSched  = 16;
  localparam int unsigned NumRounds = 80;

endpackage

// ===== hdl/sha1bc_round.sv =====
// One SHA-1 round: the shared datapath that the sequencer runs eighty times.
module sha1bc_round
  import sha1bc_pkg::*;
(
  input  logic [6:0] round_i,
  input  vars_t      vars_i,
  input  word_t      w_i,
  output vars_t      vars_o
);

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam logic [6:0] EndChoose   = 7'd20;
  localparam logic [6:0] EndParity   = 7'd40;
  localparam logic [6:0] EndMajority = 7'd60;

  word_t fk;
  word_t rot_a;
  word_t sum;

  // Round function and constant, chosen by the stage of twenty rounds.
  always_comb begin
    if (round_i < EndChoose) begin
      fk = ((vars_i.b & (vars_i.c ^ vars_i.d)) ^ vars_i.d) + K0;
    end else if (round_i < EndParity) begin
      fk = (vars_i.b ^ vars_i.c ^ vars_i.d) + K1;
    end else if (round_i < EndMajority) begin
      fk = ((vars_i.b & vars_i.c) | (vars_i.d & (vars_i.b ^ vars_i.c))) + K2;
    end else begin
      fk = (vars_i.b ^ vars_i.c ^ vars_i.d) + K3;
    end
  end

  // New A is the sum of E, A rotated by five, the function term and the word.
  assign rot_a = {vars_i.a[26:0], vars_i.a[31:27]};
  assign sum   = vars_i.e + rot_a + fk + w_i;

  // The variables move down by one place; B is rotated by thirty into C.
  always_comb begin
    vars_o.a = sum;
    vars_o.b = vars_i.a;
    vars_o.c = {vars_i.b[1:0], vars_i.b[31:2]};
    vars_o.d = vars_i.c;
    vars_o.e = vars_i.d;
  end

endmodule

// ===== hdl/sha1_block_compression_core.sv =====
// Top level of the SHA-1 block compression core: sequencer, schedule and output register.
//
// Usage: the input channel takes one word per accepted handshake. A load word
// (operation 0) writes chaining word A to E at once; an index of five or more
// is dropped. A message word (operation 1) is shifted into the schedule, and
// the sixteenth one of a block starts the compression.
// Sequence: loads and the first fifteen message words give no result. The
// sixteenth word is followed by the rounds, one round per cycle in the shared
// round datapath, and then by the feed-forward state. The emit state then loads
// the five result words into the output register, from word A on, one per cycle
// while the receiver takes them. The input stalls from the sixteenth word until
// the fifth result word has entered the output register; a stalled receiver
// holds the output register and so holds the emission. Reset clears the
// chaining value to zero, the word count and the sequencer; the schedule and
// working variables are left as they are until written.
module sha1_block_compression_core
  import sha1bc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [2:0]  chain_index_i,
  input  logic [31:0] data_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  out_index_o,
  output logic [31:0] out_word_o,
  output logic        last_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_FEED  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  localparam logic [6:0] LastRound = 7'(NumRounds - 1);
  localparam logic [2:0] LastChain = 3'(NumChain - 1);
  localparam logic [3:0] LastWord  = 4'(NumSched - 1);

  state_e     state_q, state_d;
  word_t      chain_q [NumChain];
  word_t      sched_q [NumSched];
  vars_t      vars_q;
  vars_t      vars_next;
  logic [3:0] words_q;
  logic [6:0] round_q;
  logic [2:0] emit_idx_q;
  logic       out_valid_q;
  logic [2:0] out_index_q;
  word_t      out_word_q;
  logic       out_last_q;

  logic       in_take;
  logic       msg_take;
  logic       block_full;
  logic       out_free;
  logic       emit_load;
  word_t      w_new;

  // Handshake conditions.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign msg_take   = in_take && (operation_i == OpMessage);
  assign block_full = msg_take && (words_q == LastWord);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit_load  = (state_q == ST_EMIT) && out_free;

  // Next schedule word from the fixed taps of the window.
  assign w_new = {sched_q[13][30:0] ^ sched_q[8][30:0] ^ sched_q[2][30:0] ^ sched_q[0][30:0],
                  sched_q[13][31] ^ sched_q[8][31] ^ sched_q[2][31] ^ sched_q[0][31]};

  // Shared round datapath.
  sha1bc_round u_round (
    .round_i (round_q),
    .vars_i  (vars_q),
    .w_i     (sched_q[0]),
    .vars_o  (vars_next)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (block_full) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (round_q == LastRound) begin
          state_d = ST_FEED;
        end
      end
      ST_FEED: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free && (emit_idx_q == LastChain)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      words_q     <= '0;
      round_q     <= '0;
      emit_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (msg_take) begin
        words_q <= words_q + 4'd1;
      end
      if (state_q == ST_ROUND) begin
        round_q <= (round_q == LastRound) ? '0 : round_q + 7'd1;
      end
      if (state_q == ST_FEED) begin
        emit_idx_q <= '0;
      end else if (emit_load) begin
        emit_idx_q <= emit_idx_q + 3'd1;
      end
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Chaining value: direct loads while idle, feed-forward after the rounds.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChain; i++) begin
        chain_q[i] <= '0;
      end
    end else if (in_take && (operation_i == OpLoad) && (chain_index_i <= LastChain)) begin
      chain_q[chain_index_i] <= data_word_i;
    end else if (state_q == ST_FEED) begin
      chain_q[0] <= chain_q[0] + vars_q.a;
      chain_q[1] <= chain_q[1] + vars_q.b;
      chain_q[2] <= chain_q[2] + vars_q.c;
      chain_q[3] <= chain_q[3] + vars_q.d;
      chain_q[4] <= chain_q[4] + vars_q.e;
    end
  end

  // Schedule window: shifts in message words, then expands one word per round.
  always_ff @(posedge clk_i) begin
    if (msg_take || (state_q == ST_ROUND)) begin
      for (int i = 0; i < NumSched - 1; i++) begin
        sched_q[i] <= sched_q[i + 1];
      end
      sched_q[NumSched - 1] <= msg_take ? data_word_i : w_new;
    end
  end

  // Working variables start from the chaining value as it stands.
  always_ff @(posedge clk_i) begin
    if (block_full) begin
      vars_q <= '{a: chain_q[0], b: chain_q[1], c: chain_q[2], d: chain_q[3], e: chain_q[4]};
    end else if (state_q == ST_ROUND) begin
      vars_q <= vars_next;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      out_index_q <= emit_idx_q;
      out_word_q  <= chain_q[emit_idx_q];
      out_last_q  <= (emit_idx_q == LastChain);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_index_q;
  assign out_word_o  = out_word_q;
  assign last_o      = out_last_q;

`ifndef NO_ASSERTIONS
  // The sixteenth message word starts the rounds at round zero.
  a_block_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    block_full |=> (state_q == ST_ROUND) && (round_q == '0))
    else $error("rounds did not start after a full block");

  // The last round leads into the feed-forward cycle.
  a_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) && (round_q == LastRound) |=> (state_q == ST_FEED))
    else $error("feed-forward did not follow the last round");

  // Emission begins at word A right after the feed-forward.
  a_emit_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FEED) |=> (state_q == ST_EMIT) && (emit_idx_q == '0))
    else $error("emission did not start at word A");

  // The input is never taken while a block is being worked on.
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_take)
    else $error("input word taken while busy");
`endif

endmodule
